### sv/assert_macros.svh
// Assertion helpers used by the RTL (included by rar_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define RAR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define RAR_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`endif

### sv/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational arithmetic reducer.
// ----------------------------------------------------------------------------
package rar_pkg;
    localparam int OpW   = 16;
    localparam int ProdW = 2 * OpW;
    localparam int SumW  = ProdW + 1;
    localparam int NumW  = 33;
    localparam int DenW  = 32;
    localparam int CntW  = $clog2(SumW + 1);

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic gcd_step;
        logic div_start;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } t_status;
endpackage

### sv/rar_datapath.sv
// ----------------------------------------------------------------------------
// rar_datapath
// Cross products, binary GCD and restoring divisions by the GCD.
// ----------------------------------------------------------------------------
module rar_datapath (
    input  logic                        i_clk,
    input  rar_pkg::t_cmd               i_cmd,
    output rar_pkg::t_status            o_status,
    input  logic [1:0]                  i_func,
    input  logic signed [rar_pkg::OpW-1:0] i_a_num,
    input  logic signed [rar_pkg::OpW-1:0] i_a_den,
    input  logic signed [rar_pkg::OpW-1:0] i_b_num,
    input  logic signed [rar_pkg::OpW-1:0] i_b_den,
    output logic signed [rar_pkg::NumW-1:0] o_res_num,
    output logic signed [rar_pkg::DenW-1:0] o_res_den,
    output logic                        o_zero_div
);
    import rar_pkg::*;

    logic [1:0]                r_func;
    logic signed [OpW-1:0]     r_an, r_ad, r_bn, r_bd;
    logic signed [ProdW-1:0]   r_p0, r_p1, r_p2;
    logic signed [SumW-1:0]    r_top;
    logic signed [ProdW-1:0]   r_bot;
    logic [SumW-1:0]           r_x, r_y;
    logic [CntW-1:0]           r_k;
    logic [SumW-1:0]           r_g;
    logic [SumW-1:0]           r_qn, r_remn;
    logic [SumW-1:0]           r_qd, r_remd;
    logic [CntW-1:0]           r_cnt;
    logic                      r_zd;

    logic [SumW-1:0] mag_top, mag_bot, diff, n_remn, n_remd;
    logic [SumW:0]   tn, td;

    assign mag_top = r_top[SumW-1] ? SumW'(-r_top) : SumW'(r_top);
    assign mag_bot = r_bot[ProdW-1] ? SumW'(-{r_bot[ProdW-1], r_bot}) : SumW'(r_bot);
    assign diff    = (r_x > r_y) ? r_x - r_y : r_y - r_x;
    assign n_remn  = {r_remn[SumW-2:0], r_qn[SumW-1]};
    assign n_remd  = {r_remd[SumW-2:0], r_qd[SumW-1]};
    assign tn      = {1'b0, n_remn} - {1'b0, r_g};
    assign td      = {1'b0, n_remd} - {1'b0, r_g};

    assign o_status.gcd_done = (r_x == r_y) || (r_x == '0) || (r_y == '0);
    assign o_status.div_done = (r_cnt == CntW'(SumW));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_an <= i_a_num; r_ad <= i_a_den; r_bn <= i_b_num; r_bd <= i_b_den;
        end
        if (i_cmd.mul) begin
            r_p1 <= ProdW'(r_bn * r_ad);
            case (r_func)
                FUNC_MUL: begin
                    r_p0 <= ProdW'(r_an * r_bn);
                    r_p2 <= ProdW'(r_ad * r_bd);
                end
                FUNC_DIV: begin
                    r_p0 <= ProdW'(r_an * r_bd);
                    r_p2 <= ProdW'(r_ad * r_bn);
                end
                default: begin
                    r_p0 <= ProdW'(r_an * r_bd);
                    r_p2 <= ProdW'(r_ad * r_bd);
                end
            endcase
        end
        if (i_cmd.sum) begin
            case (r_func)
                FUNC_ADD: r_top <= SumW'(r_p0) + SumW'(r_p1);
                FUNC_SUB: r_top <= SumW'(r_p0) - SumW'(r_p1);
                default:  r_top <= SumW'(r_p0);
            endcase
            r_bot <= r_p2;
        end
        if (i_cmd.gcd_step) begin
            // seed from magnitudes, then strip shared twos and subtract
            if (r_cnt == '0) begin
                r_x <= mag_top; r_y <= mag_bot; r_k <= '0; r_cnt <= CntW'(1);
                r_zd <= (r_bot == '0);
            end else if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1; r_y <= r_y >> 1; r_k <= r_k + CntW'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x > r_y) begin
                r_x <= diff;
            end else begin
                r_y <= diff;
            end
        end
        if (i_cmd.div_start) begin
            r_g  <= ((r_x == '0) ? r_y : r_x) << r_k;
            r_qn <= mag_top; r_remn <= '0;
            r_qd <= mag_bot; r_remd <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_remn <= tn[SumW] ? n_remn : tn[SumW-1:0];
            r_remd <= td[SumW] ? n_remd : td[SumW-1:0];
            r_qn <= {r_qn[SumW-2:0], ~tn[SumW]};
            r_qd <= {r_qd[SumW-2:0], ~td[SumW]};
            r_cnt <= r_cnt + CntW'(1);
        end
        if (i_cmd.load) r_cnt <= '0;
    end

    always_comb begin
        o_zero_div = r_zd;
        if (r_zd || r_top == '0) begin
            o_res_num = NumW'(0);
            o_res_den = DenW'(1);
        end else begin
            o_res_num = r_top[SumW-1] ? NumW'(-r_qn) : NumW'(r_qn);
            o_res_den = r_bot[ProdW-1] ? DenW'(-r_qd) : DenW'(r_qd);
        end
    end
endmodule

### sv/rar_ctrl.sv
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer for load, multiply, sum, GCD, divide and result hand-off.
// ----------------------------------------------------------------------------
module rar_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  rar_pkg::t_status i_status,
    output rar_pkg::t_cmd    o_cmd
);
    import rar_pkg::*;
    `include "assert_macros.svh"

    t_state r_state, n_state;
    logic   r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seed  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seed  <= (n_state == ST_GCD) && (r_state != ST_GCD);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_GCD;
            ST_GCD:  if (!r_seed && i_status.gcd_done) n_state = ST_DIV;
            ST_DIV:  if (i_status.div_done) n_state = ST_OUT;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_SUM:  o_cmd.sum = 1'b1;
            ST_GCD: begin
                o_cmd.gcd_step  = r_seed || !i_status.gcd_done;
                o_cmd.div_start = !r_seed && i_status.gcd_done;
            end
            ST_DIV:  o_cmd.div_step = !i_status.div_done;
            ST_OUT:  o_valid = 1'b1;
            default: ;
        endcase
    end

    `RAR_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped")
    `RAR_NEVER(a_one_side, i_clk, i_rst_n, o_ready && o_valid, "ready with result")
    `RAR_ASSERT(a_load_idle, i_clk, i_rst_n, o_cmd.load |=> (r_state == ST_MUL), "bad load")
endmodule

### sv/rational_arithmetic_reduce.sv
// Load, multiply, sum, binary GCD steps and divide steps run in turn; the GCD part is data dependent.
// A new request is accepted only in idle, after the previous result has been taken.
// Two restoring dividers share the GCD and run in parallel.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce
// Adds, subtracts, multiplies or divides fractions and reduces the result.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_func,
    input  logic signed [rar_pkg::OpW-1:0]  i_a_num,
    input  logic signed [rar_pkg::OpW-1:0]  i_a_den,
    input  logic signed [rar_pkg::OpW-1:0]  i_b_num,
    input  logic signed [rar_pkg::OpW-1:0]  i_b_den,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [rar_pkg::NumW-1:0] o_res_num,
    output logic signed [rar_pkg::DenW-1:0] o_res_den,
    output logic                            o_zero_div
);
    import rar_pkg::*;

    t_cmd    cmd;
    t_status status;

    rar_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_status(status), .o_cmd(cmd)
    );

    rar_datapath u_dp (
        .i_clk, .i_cmd(cmd), .o_status(status), .i_func,
        .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_res_num, .o_res_den, .o_zero_div
    );
endmodule
